// ----- rtl/rc4_pkg.sv -----
// Shared constants, command codes and the permutation memory request type.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_DEPTH  = 256;
  localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KEY_CW     = $clog2(KEY_DEPTH + 1);
  localparam int PERM_DEPTH = 256;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SCHED  = 2'd1;
  localparam logic [1:0] CMD_CIPHER = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [7:0] ROUNDS_RESET = 8'd1;
  localparam logic [7:0] LAST_INDEX   = 8'hFF;

  typedef struct packed {
    logic       clr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage

// ----- rtl/rc4_perm_ram.sv -----
// Permutation memory: 256x8, one write and one read port, identity until written.
`timescale 1ns / 1ps

module rc4_perm_ram
  import rc4_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  perm_req_t req,
  output logic [7:0] rdata
);

  logic [7:0]            mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] valid_r;
  logic [7:0]            rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Entries not written since the last clear read back as their own address.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  // Write-first: a read of the entry being written returns the new data.
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr == req.raddr)) begin
      rdata_r <= req.wdata;
    end else if (valid_r[req.raddr]) begin
      rdata_r <= mem[req.raddr];
    end else begin
      rdata_r <= req.raddr;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rc4_key_ram.sv -----
// Key store memory: KEY_DEPTH x 8, one write and one registered read port.
`timescale 1ns / 1ps

module rc4_key_ram
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [KEY_AW-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [KEY_AW-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [KEY_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rc4_multi_round_stream_cipher.sv -----
// RC4 cipher top level: command decode, schedule and keystream sequencer.
// Load key and no-op requests finish at the accepting edge; busy stays low.
// Cipher request: result strobe after the read, read, write, write+read, output
//   sequence on the permutation memory (one write and one read port); busy is low
//   again when the strobe rises, so the next request can be taken then.
// Schedule request: busy for max(rounds, 1) passes over the 256 entries with a key
//   loaded (one read, write, write+read swap per entry), none without.
// Reset (rst_n, synchronous): permutation reads as identity through per-entry
//   valid flags, i, j and key count zero, rounds 1; key store is not cleared.
`timescale 1ns / 1ps

module rc4_multi_round_stream_cipher
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  output logic [7:0] out_cipher_byte,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_J,      // cipher: have S[i], fetch S[j]
    ST_C_SW1,    // cipher: write S[i] = S[j]
    ST_C_SW2,    // cipher: write S[j] = old S[i], fetch S[a+b]
    ST_C_OUT,    // cipher: keystream byte on the read port
    ST_K_INIT,   // schedule: first fetch of S[0] and key[0]
    ST_K_J,      // schedule: have S[k] and key byte, fetch S[j]
    ST_K_SW1,    // schedule: write S[k] = S[j]
    ST_K_SW2     // schedule: write S[j] = old S[k], fetch next k
  } state_t;

  state_t            state_r;
  logic [7:0]        i_r;
  logic [7:0]        j_r;
  logic [7:0]        a_r;
  logic [7:0]        b_r;
  logic [7:0]        k_r;
  logic [7:0]        pass_r;
  logic [KEY_AW-1:0] kidx_r;
  logic [KEY_CW-1:0] count_r;
  logic [7:0]        byte_r;
  logic [7:0]        rounds_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;

  perm_req_t         perm_req;
  logic [7:0]        perm_rdata;
  logic [KEY_AW-1:0] key_raddr;
  logic [7:0]        key_rdata;
  logic              key_we;

  logic              accept;
  logic              key_full;
  logic [7:0]        rounds_last;
  logic              sched_done;
  logic              kidx_wrap;
  logic [KEY_AW-1:0] kidx_nxt;
  logic [7:0]        mix_j;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign key_full = (count_r == KEY_CW'(KEY_DEPTH));
  assign key_we   = accept && (in_command == CMD_LOAD) && !key_full;

  // A rounds value of zero runs one pass.
  assign rounds_last = (rounds_r == 8'd0) ? 8'd0 : rounds_r - 8'd1;
  assign sched_done  = (k_r == LAST_INDEX) && (pass_r == rounds_last);

  // Key index walks k mod key_count; restarts at every pass.
  assign kidx_wrap = ((KEY_CW'(kidx_r) + KEY_CW'(1)) == count_r);
  assign kidx_nxt  = ((k_r == LAST_INDEX) || kidx_wrap) ? '0 : kidx_r + KEY_AW'(1);

  assign mix_j = j_r + perm_rdata + key_rdata;

  // Memory requests for the current step.
  always_comb begin
    perm_req  = '0;
    key_raddr = kidx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_command == CMD_CIPHER)) begin
          perm_req.raddr = i_r + 8'd1;
        end
        if (accept && (in_command == CMD_SCHED)) begin
          perm_req.clr = 1'b1;
        end
      end
      ST_C_J: begin
        perm_req.raddr = j_r + perm_rdata;
      end
      ST_C_SW1: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = i_r;
        perm_req.wdata = perm_rdata;
      end
      ST_C_SW2: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = a_r;
        perm_req.raddr = a_r + b_r;
      end
      ST_K_INIT: begin
        perm_req.raddr = k_r;
      end
      ST_K_J: begin
        perm_req.raddr = mix_j;
      end
      ST_K_SW1: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = k_r;
        perm_req.wdata = perm_rdata;
      end
      ST_K_SW2: begin
        // Next fetch overlaps this write; the memory forwards on a match.
        perm_req.we    = 1'b1;
        perm_req.waddr = j_r;
        perm_req.wdata = a_r;
        perm_req.raddr = k_r + 8'd1;
        key_raddr      = kidx_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= 8'd0;
      j_r         <= 8'd0;
      count_r     <= '0;
      rounds_r    <= ROUNDS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // Strobe for one cycle after the output step.
      out_valid_r <= (state_r == ST_C_OUT);
      if (cfg_wr_en) begin
        rounds_r <= cfg_wr_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            byte_r <= in_byte_value;
            case (in_command)
              CMD_LOAD: begin
                if (!key_full) begin
                  count_r <= count_r + KEY_CW'(1);
                end
              end
              CMD_SCHED: begin
                i_r <= 8'd0;
                j_r <= 8'd0;
                if (count_r != '0) begin
                  k_r     <= 8'd0;
                  kidx_r  <= '0;
                  pass_r  <= 8'd0;
                  state_r <= ST_K_INIT;
                end
              end
              CMD_CIPHER: begin
                i_r     <= i_r + 8'd1;
                state_r <= ST_C_J;
              end
              default: begin
              end
            endcase
          end
        end
        ST_C_J: begin
          a_r     <= perm_rdata;
          j_r     <= j_r + perm_rdata;
          state_r <= ST_C_SW1;
        end
        ST_C_SW1: begin
          b_r     <= perm_rdata;
          state_r <= ST_C_SW2;
        end
        ST_C_SW2: begin
          state_r <= ST_C_OUT;
        end
        ST_C_OUT: begin
          out_byte_r  <= byte_r ^ perm_rdata;
          state_r     <= ST_IDLE;
        end
        ST_K_INIT: begin
          state_r <= ST_K_J;
        end
        ST_K_J: begin
          a_r     <= perm_rdata;
          j_r     <= mix_j;
          state_r <= ST_K_SW1;
        end
        ST_K_SW1: begin
          state_r <= ST_K_SW2;
        end
        ST_K_SW2: begin
          if (sched_done) begin
            j_r     <= 8'd0;
            count_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            k_r    <= k_r + 8'd1;
            kidx_r <= kidx_nxt;
            if (k_r == LAST_INDEX) begin
              pass_r <= pass_r + 8'd1;
            end
            state_r <= ST_K_J;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  rc4_perm_ram u_perm_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (perm_req),
    .rdata (perm_rdata)
  );

  rc4_key_ram u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (count_r[KEY_AW-1:0]),
    .wdata (in_byte_value),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_cipher_byte = out_byte_r;

endmodule

// ----- rtl/rc4_checker.sv -----
// Port-level timing checks for the RC4 cipher and their bind to the top level.
`timescale 1ns / 1ps

module rc4_checker
  import rc4_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input logic       out_valid
);

  logic cipher_req;
  logic short_req;

  assign cipher_req = start && !busy && (in_command == CMD_CIPHER);
  assign short_req  = start && !busy &&
                      ((in_command == CMD_LOAD) || (in_command == CMD_NOP));

  a_cipher_result: assert property (@(posedge clk) disable iff (!rst_n)
    cipher_req |-> ##5 (out_valid && !busy))
    else $error("cipher request gave no result on time");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cipher_req, 5))
    else $error("result strobe without a cipher request");

  a_cipher_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cipher_req |=> busy)
    else $error("busy not raised for a cipher request");

  a_short_req: assert property (@(posedge clk) disable iff (!rst_n)
    short_req |=> (!busy && !out_valid))
    else $error("load or no-op request held the block");

endmodule

bind rc4_multi_round_stream_cipher rc4_checker u_rc4_checker (.*);
